// File: src/slcj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slcj_pkg;

   localparam int QUAT_W    = 64;
   localparam int VEC_W     = 63;
   localparam int QC_W      = 16;
   localparam int VC_W      = 21;
   localparam int R_W       = 27;
   localparam int TS_W      = 24;
   localparam int DEN_W     = 27;
   localparam int NUM_W     = 63;
   localparam int DIV_STEPS = 32;
   localparam int SIDE_W    = 32 + 4 * VEC_W;
   localparam int IN_W      = 256;
   localparam int OUT_W     = 320;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 64;
   localparam logic [TS_W-1:0] TS_RESET = 24'd279620;

   typedef logic signed [QC_W-1:0] qc_type;
   typedef logic signed [VC_W-1:0] vc_type;
   typedef logic signed [R_W-1:0]  rv_type;

   typedef enum logic [1:0] {
      CSR_PARENT_LINK = 2'd0,
      CSR_CHILD_LINK  = 2'd1,
      CSR_SLIDE_AXIS  = 2'd2,
      CSR_TIME_STEP   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic child_fixed;
      logic parent_fixed;
   } flags_type;

   typedef struct packed {
      logic             big;
      logic             neg;
      logic [NUM_W-1:0] num;
   } div_in_type;

   function automatic logic [VC_W-1:0] sat_comp(input logic signed [57:0] x);
      logic [VC_W-1:0] r;
      if (x > 58'sd1048575) begin
         r = 21'h0FFFFF;
      end else if (x < -58'sd1048576) begin
         r = 21'h100000;
      end else begin
         r = x[VC_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: src/slcj_rotate.sv
`timescale 1ns / 1ps
`default_nettype none

module slcj_rotate import slcj_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [QUAT_W-1:0] quat,
   input  logic [VEC_W-1:0]  vec,
   output rv_type            rot [3]
);

   qc_type w0;
   qc_type u0 [3];
   vc_type v0 [3];

   logic signed [31:0] ww_ff;
   logic signed [31:0] uu_ff [3];
   logic signed [36:0] uv_ff [3][3];
   qc_type             w1_ff;
   qc_type             u1_ff [3];
   vc_type             v1_ff [3];

   logic signed [33:0] k_in;
   logic signed [38:0] d_in;
   logic signed [37:0] c_in [3];
   logic signed [33:0] k_ff;
   logic signed [38:0] d_ff;
   logic signed [37:0] c_ff [3];
   qc_type             w2_ff;
   qc_type             u2_ff [3];
   vc_type             v2_ff [3];

   logic signed [55:0] kv_ff [3];
   logic signed [55:0] du_ff [3];
   logic signed [55:0] wc_ff [3];

   logic signed [59:0] s_sum [3];
   rv_type             rot_in [3];
   rv_type             rot_ff [3];

   always_comb begin
      w0 = qc_type'(quat[QC_W-1:0]);
      for (int i = 0; i < 3; i++) begin
         u0[i] = qc_type'(quat[QC_W*(i+1) +: QC_W]);
         v0[i] = vc_type'(vec[VC_W*i +: VC_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= w0 * w0;
         w1_ff <= w0;
         for (int i = 0; i < 3; i++) begin
            uu_ff[i] <= u0[i] * u0[i];
            u1_ff[i] <= u0[i];
            v1_ff[i] <= v0[i];
            for (int j = 0; j < 3; j++) begin
               uv_ff[i][j] <= u0[i] * v0[j];
            end
         end
      end
   end

   always_comb begin
      k_in = 34'(ww_ff) - 34'(uu_ff[0]) - 34'(uu_ff[1]) - 34'(uu_ff[2]);
      d_in = 39'(uv_ff[0][0]) + 39'(uv_ff[1][1]) + 39'(uv_ff[2][2]);
      for (int i = 0; i < 3; i++) begin
         c_in[i] = 38'(uv_ff[(i+1)%3][(i+2)%3]) - 38'(uv_ff[(i+2)%3][(i+1)%3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_ff  <= k_in;
         d_ff  <= d_in;
         w2_ff <= w1_ff;
         for (int i = 0; i < 3; i++) begin
            c_ff[i]  <= c_in[i];
            u2_ff[i] <= u1_ff[i];
            v2_ff[i] <= v1_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            kv_ff[i] <= k_ff * v2_ff[i];
            du_ff[i] <= d_ff * u2_ff[i];
            wc_ff[i] <= w2_ff * c_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s_sum[i] = 60'(kv_ff[i]) + (60'(du_ff[i]) <<< 1) - (60'(wc_ff[i]) <<< 1)
                    + 60'sd134217728;
         rot_in[i] = R_W'(s_sum[i] >>> 28);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            rot_ff[i] <= rot_in[i];
         end
      end
   end

   assign rot = rot_ff;

endmodule

`default_nettype wire

// File: src/slcj_geom.sv
`timescale 1ns / 1ps
`default_nettype none

module slcj_geom import slcj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               valid_in,
   input  rv_type             pl_rot [3],
   input  rv_type             n_rot [3],
   input  rv_type             cr_rot [3],
   input  logic [VEC_W-1:0]   parent_pos,
   input  logic [VEC_W-1:0]   child_pos,
   input  flags_type          flags,
   input  logic [DEN_W-1:0]   den,
   output logic               valid_out,
   output div_in_type         div_out,
   output logic [SIDE_W-1:0]  side_out
);

   vc_type             pp [3];
   vc_type             cp [3];
   logic signed [27:0] pl [3];
   logic signed [27:0] cl [3];
   logic signed [28:0] dd_in [3];
   logic signed [28:0] dp_in [3];

   logic               v5_ff, v6_ff, v7_ff, v8_ff;
   flags_type          f5_ff, f6_ff, f7_ff;
   rv_type             n5_ff [3];
   rv_type             n6_ff [3];
   rv_type             n7_ff [3];
   rv_type             cr5_ff [3];
   logic signed [28:0] dd5_ff [3];
   logic signed [28:0] dp5_ff [3];

   logic signed [55:0] dn6_ff [3];
   logic signed [55:0] pa6_ff [3];
   logic signed [55:0] pb6_ff [3];
   logic signed [55:0] ca6_ff [3];
   logic signed [55:0] cb6_ff [3];

   logic signed [57:0] c20_ff;
   logic signed [56:0] cx1_ff [3];
   logic signed [56:0] cx2_ff [3];

   logic signed [57:0] c16;
   logic signed [57:0] t1, t2;
   logic [31:0]        sep;
   logic [VC_W-1:0]    jpl [3];
   logic [VC_W-1:0]    jpa [3];
   logic [VC_W-1:0]    jcl [3];
   logic [VC_W-1:0]    jca [3];
   logic [VEC_W-1:0]   jpl_w, jpa_w, jcl_w, jca_w;
   logic [57:0]        mag;
   div_in_type         div_in;
   logic [SIDE_W-1:0]  side_in;
   div_in_type         div_ff;
   logic [SIDE_W-1:0]  side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pp[i]    = vc_type'(parent_pos[VC_W*i +: VC_W]);
         cp[i]    = vc_type'(child_pos[VC_W*i +: VC_W]);
         pl[i]    = 28'(pl_rot[i]) + 28'(pp[i]);
         cl[i]    = 28'(cr_rot[i]) + 28'(cp[i]);
         dd_in[i] = 29'(cl[i]) - 29'(pl[i]);
         dp_in[i] = 29'(cl[i]) - 29'(pp[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= valid_in;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f5_ff <= flags;
         f6_ff <= f5_ff;
         f7_ff <= f6_ff;
         for (int i = 0; i < 3; i++) begin
            n5_ff[i]  <= n_rot[i];
            cr5_ff[i] <= cr_rot[i];
            dd5_ff[i] <= dd_in[i];
            dp5_ff[i] <= dp_in[i];
            n6_ff[i]  <= n5_ff[i];
            n7_ff[i]  <= n6_ff[i];
            dn6_ff[i] <= dd5_ff[i] * n5_ff[i];
            pa6_ff[i] <= n5_ff[(i+1)%3] * dp5_ff[(i+2)%3];
            pb6_ff[i] <= n5_ff[(i+2)%3] * dp5_ff[(i+1)%3];
            ca6_ff[i] <= n5_ff[(i+1)%3] * cr5_ff[(i+2)%3];
            cb6_ff[i] <= n5_ff[(i+2)%3] * cr5_ff[(i+1)%3];
            cx1_ff[i] <= 57'(pa6_ff[i]) - 57'(pb6_ff[i]);
            cx2_ff[i] <= 57'(ca6_ff[i]) - 57'(cb6_ff[i]);
         end
         c20_ff <= 58'(dn6_ff[0]) + 58'(dn6_ff[1]) + 58'(dn6_ff[2]);
      end
   end

   always_comb begin
      c16 = (c20_ff + 58'sd8) >>> 4;
      if (c16 > 58'sd2147483647) begin
         sep = 32'h7FFFFFFF;
      end else if (c16 < -58'sd2147483648) begin
         sep = 32'h80000000;
      end else begin
         sep = c16[31:0];
      end
      t1 = '0;
      t2 = '0;
      for (int i = 0; i < 3; i++) begin
         t1     = (58'(cx1_ff[i]) + 58'sd512) >>> 10;
         t2     = (58'(cx2_ff[i]) + 58'sd512) >>> 10;
         jpa[i] = sat_comp(t1);
         jca[i] = sat_comp(-t2);
         jcl[i] = sat_comp(58'(n7_ff[i]));
         jpl[i] = sat_comp(-58'(n7_ff[i]));
      end
      jpl_w = {jpl[2], jpl[1], jpl[0]};
      jpa_w = {jpa[2], jpa[1], jpa[0]};
      jcl_w = {jcl[2], jcl[1], jcl[0]};
      jca_w = {jca[2], jca[1], jca[0]};
      if (f7_ff.parent_fixed) begin
         jpl_w = '0;
         jpa_w = '0;
      end else if (f7_ff.child_fixed) begin
         jcl_w = '0;
         jca_w = '0;
      end
      mag        = c16[57] ? 58'(-c16) : 58'(c16);
      div_in.big = |mag[57:38];
      div_in.neg = c16[57];
      div_in.num = NUM_W'({mag[37:0], 24'b0}) + NUM_W'(den[DEN_W-1:1]);
      side_in    = {jca_w, jcl_w, jpa_w, jpl_w, sep};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         div_ff  <= div_in;
         side_ff <= side_in;
      end
   end

   assign valid_out = v8_ff;
   assign div_out   = div_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

// File: src/slcj_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module slcj_divider import slcj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               valid_in,
   input  div_in_type         din,
   input  logic [SIDE_W-1:0]  side_in,
   input  logic [DEN_W-1:0]   den,
   output logic               valid_out,
   output logic [31:0]        bias,
   output logic [SIDE_W-1:0]  side_out
);

   logic [DIV_STEPS:0] valid_ff;
   logic [DIV_STEPS:0] ovf_ff;
   logic [DIV_STEPS:0] neg_ff;
   logic [DEN_W-1:0]   rem_ff  [DIV_STEPS+1];
   logic [31:0]        q_ff    [DIV_STEPS+1];
   logic [31:0]        low_ff  [DIV_STEPS+1];
   logic [SIDE_W-1:0]  side_ff [DIV_STEPS+1];

   logic [DEN_W-1:0]   rem_in  [DIV_STEPS+1];
   logic [31:0]        q_in    [DIV_STEPS+1];
   logic [31:0]        low_in  [DIV_STEPS+1];
   logic [DEN_W:0]     trial   [DIV_STEPS+1];
   logic               ge      [DIV_STEPS+1];

   logic               valid_out_ff;
   logic               ovf_out_ff;
   logic [31:0]        bias_in, bias_ff;
   logic [SIDE_W-1:0]  side_out_ff;
   logic [31:0]        q_last;

   always_comb begin
      rem_in[0] = DEN_W'(din.num[NUM_W-1:32]);
      q_in[0]   = '0;
      low_in[0] = din.num[31:0];
      trial[0]  = '0;
      ge[0]     = 1'b0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][31]};
         ge[k]     = trial[k] >= {1'b0, den};
         rem_in[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den}) : DEN_W'(trial[k]);
         q_in[k]   = {q_ff[k-1][30:0], ge[k]};
         low_in[k] = {low_ff[k-1][30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STEPS-1:0], valid_in};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0]  <= din.big || (din.num[NUM_W-1:32] >= 31'(den));
         neg_ff[0]  <= din.neg;
         side_ff[0] <= side_in;
         for (int k = 1; k <= DIV_STEPS; k++) begin
            ovf_ff[k]  <= ovf_ff[k-1];
            neg_ff[k]  <= neg_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k <= DIV_STEPS; k++) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            low_ff[k] <= low_in[k];
         end
      end
   end

   always_comb begin
      q_last = q_ff[DIV_STEPS];
      if (ovf_ff[DIV_STEPS]) begin
         bias_in = neg_ff[DIV_STEPS] ? 32'h80000000 : 32'h7FFFFFFF;
      end else if (neg_ff[DIV_STEPS]) begin
         bias_in = (q_last > 32'h80000000) ? 32'h80000000 : -q_last;
      end else begin
         bias_in = q_last[31] ? 32'h7FFFFFFF : q_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out_ff <= 1'b0;
      end else if (en) begin
         valid_out_ff <= valid_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_out_ff  <= ovf_ff[DIV_STEPS];
         bias_ff     <= bias_in;
         side_out_ff <= side_ff[DIV_STEPS];
      end
   end

   assign valid_out = valid_out_ff;
   assign bias      = bias_ff;
   assign side_out  = side_out_ff;

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_STEPS] && !ovf_ff[DIV_STEPS] |-> rem_ff[DIV_STEPS] < den)
      else $error("Division remainder is not below the divisor.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en && valid_out_ff |=> valid_out_ff && $stable(bias_ff) && $stable(side_out_ff))
      else $error("Held result changed during a stall.");

   a_ovf_saturates: assert property (@(posedge clock) disable iff (reset)
      valid_out_ff && ovf_out_ff |-> bias_ff == 32'h80000000 || bias_ff == 32'h7FFFFFFF)
      else $error("Overflowed bias is not saturated.");

endmodule

`default_nettype wire

// File: src/slider_constraint_jacobian.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Width      Contents
// req      in         256 + 2    two quaternions, two positions; tuser fixed flags
// rsp      out        320        separation, bias, four Jacobian vectors
// csr      in/out     64, addr 5 link points, slide axis, time step at 8*i
//
// One item per cycle, while no stalled result holds the pipeline.
// The 32 stages of the restoring bias divider, one quotient bit each, set the depth.
// Reset is synchronous; it empties the pipeline and loads the register defaults.
// A stalled result holds the whole pipeline, so nothing is lost or repeated.

module slider_constraint_jacobian import slcj_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // parent_orientation, parent_position, child_orientation, child_position
   input  logic [IN_W-1:0]    req_tdata,
   // parent_fixed, child_fixed
   input  logic [1:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // separation, bias_velocity, jac_parent_linear, jac_parent_angular,
   // jac_child_linear, jac_child_angular
   output logic [OUT_W-1:0]   rsp_tdata,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [CSR_AW-1:0]  csr_paddr,
   input  logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]  csr_prdata,
   output logic               csr_pready
);

   logic [VEC_W-1:0] plink_ff, clink_ff, axis_ff;
   logic [TS_W-1:0]  ts_ff;
   logic [DEN_W-1:0] den;
   logic [TS_W-1:0]  ts_eff;
   logic             csr_wr;
   logic             en;

   logic [3:0]       rv_ff;
   logic [VEC_W-1:0] pp_ff [4];
   logic [VEC_W-1:0] cp_ff [4];
   flags_type        fl_ff [4];
   flags_type        req_flags;

   rv_type           pl_rot [3];
   rv_type           n_rot [3];
   rv_type           cr_rot [3];

   logic             geom_valid;
   div_in_type       geom_div;
   logic [SIDE_W-1:0] geom_side;
   logic             div_valid;
   logic [31:0]      div_bias;
   logic [SIDE_W-1:0] div_side;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         plink_ff <= '0;
         clink_ff <= '0;
         axis_ff  <= '0;
         ts_ff    <= TS_RESET;
      end else if (csr_wr) begin
         case (csr_index_type'(csr_paddr[4:3]))
            CSR_PARENT_LINK: plink_ff <= csr_pwdata[VEC_W-1:0];
            CSR_CHILD_LINK:  clink_ff <= csr_pwdata[VEC_W-1:0];
            CSR_SLIDE_AXIS:  axis_ff  <= csr_pwdata[VEC_W-1:0];
            CSR_TIME_STEP:   ts_ff    <= csr_pwdata[TS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index_type'(csr_paddr[4:3]))
         CSR_PARENT_LINK: csr_prdata = CSR_DW'(plink_ff);
         CSR_CHILD_LINK:  csr_prdata = CSR_DW'(clink_ff);
         CSR_SLIDE_AXIS:  csr_prdata = CSR_DW'(axis_ff);
         CSR_TIME_STEP:   csr_prdata = CSR_DW'(ts_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign ts_eff = (ts_ff == '0) ? TS_W'(1) : ts_ff;
   assign den    = (DEN_W'(ts_eff) << 2) + DEN_W'(ts_eff);

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign req_flags  = '{child_fixed: req_tuser[1], parent_fixed: req_tuser[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= '0;
      end else if (en) begin
         rv_ff <= {rv_ff[2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff[0] <= req_tdata[126:64];
         cp_ff[0] <= req_tdata[253:191];
         fl_ff[0] <= req_flags;
         for (int i = 1; i < 4; i++) begin
            pp_ff[i] <= pp_ff[i-1];
            cp_ff[i] <= cp_ff[i-1];
            fl_ff[i] <= fl_ff[i-1];
         end
      end
   end

   slcj_rotate u_rot_plink (
      .clock (clock),
      .en    (en),
      .quat  (req_tdata[63:0]),
      .vec   (plink_ff),
      .rot   (pl_rot)
   );

   slcj_rotate u_rot_axis (
      .clock (clock),
      .en    (en),
      .quat  (req_tdata[63:0]),
      .vec   (axis_ff),
      .rot   (n_rot)
   );

   slcj_rotate u_rot_clink (
      .clock (clock),
      .en    (en),
      .quat  (req_tdata[190:127]),
      .vec   (clink_ff),
      .rot   (cr_rot)
   );

   slcj_geom u_geom (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .valid_in   (rv_ff[3]),
      .pl_rot     (pl_rot),
      .n_rot      (n_rot),
      .cr_rot     (cr_rot),
      .parent_pos (pp_ff[3]),
      .child_pos  (cp_ff[3]),
      .flags      (fl_ff[3]),
      .den        (den),
      .valid_out  (geom_valid),
      .div_out    (geom_div),
      .side_out   (geom_side)
   );

   slcj_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (geom_valid),
      .din       (geom_div),
      .side_in   (geom_side),
      .den       (den),
      .valid_out (div_valid),
      .bias      (div_bias),
      .side_out  (div_side)
   );

   assign rsp_tvalid = div_valid;
   assign rsp_tdata  = {4'b0, div_side[SIDE_W-1:32], div_bias, div_side[31:0]};

endmodule

`default_nettype wire
